// File: hw/rtl/gfsr_pkg.sv
// ----------------------------------------------------------------------------
// gfsr_pkg
// Shared widths, codes, reset values, control structs and the CRC-16 step
// for the gap-framed slave frame receiver.
// ----------------------------------------------------------------------------
package gfsr_pkg;

  localparam int unsigned BUFFER_DEPTH_DEF = 32;
  localparam int unsigned FRAME_CAP        = 32;   // longest frame ever kept

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned IDX_W      = 5;
  localparam int unsigned LEN_W      = 6;
  localparam int unsigned FAULT_W    = 26;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 26;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_OWN_ADDR    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAP_TICKS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FAULT_TICKS = 2'd2;

  localparam logic [BYTE_W-1:0]  OWN_ADDR_RST    = 8'd0;
  localparam logic [BYTE_W-1:0]  GAP_TICKS_RST   = 8'd10;
  localparam logic [FAULT_W-1:0] FAULT_TICKS_RST = 26'd10000;

  localparam logic [15:0]        CRC_INIT      = 16'hFFFF;
  localparam logic [15:0]        CRC_POLY      = 16'hA001;
  localparam logic [BYTE_W-1:0]  MIN_FRAME_LEN = 8'd4;

  localparam logic KIND_TICK = 1'b1;

  typedef enum logic [1:0] {
    STS_NONE    = 2'd0,
    STS_GOOD    = 2'd1,
    STS_CRC_ERR = 2'd2,
    STS_LEN_ERR = 2'd3
  } status_t;

  // controller -> datapath
  typedef struct packed {
    logic accept;
    logic load_single;
    logic load_emit;
  } ctl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic good_frame;   // valid in the accept cycle
    logic emit_last;
  } dp_sts_t;

  typedef struct packed {
    status_t           status;
    logic [BYTE_W-1:0] frame_byte;
    logic [IDX_W-1:0]  byte_index;
    logic [BYTE_W-1:0] frame_function;
    logic [LEN_W-1:0]  frame_length;
    logic              last_of_run;
    logic              comm_fault;
  } out_payload_t;

  // one byte of reflected CRC-16
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
    logic [15:0] c;
    c = crc_in ^ {8'd0, data};
    for (int b = 0; b < 8; b++) begin
      if (c[0]) begin
        c = {1'b0, c[15:1]} ^ CRC_POLY;
      end else begin
        c = {1'b0, c[15:1]};
      end
    end
    return c;
  endfunction

endpackage

// File: hw/rtl/gfsr_in_if.sv
// ----------------------------------------------------------------------------
// gfsr_in_if
// Input request channel: a received byte or one framing timer tick.
// ----------------------------------------------------------------------------
interface gfsr_in_if;
  logic                          valid;
  logic                          ready;
  logic                          kind;
  logic [gfsr_pkg::BYTE_W-1:0]   rx_byte;

  modport source (output valid, output kind, output rx_byte, input ready);
  modport sink   (input valid, input kind, input rx_byte, output ready);
endinterface

// File: hw/rtl/gfsr_out_if.sv
// ----------------------------------------------------------------------------
// gfsr_out_if
// Result channel: frame bytes and frame events.
// ----------------------------------------------------------------------------
interface gfsr_out_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    status;
  logic [gfsr_pkg::BYTE_W-1:0]   frame_byte;
  logic [gfsr_pkg::IDX_W-1:0]    byte_index;
  logic [gfsr_pkg::BYTE_W-1:0]   frame_function;
  logic [gfsr_pkg::LEN_W-1:0]    frame_length;
  logic                          last_of_run;
  logic                          comm_fault;

  modport source (output valid, output status, output frame_byte, output byte_index,
                  output frame_function, output frame_length, output last_of_run,
                  output comm_fault, input ready);
  modport sink   (input valid, input status, input frame_byte, input byte_index,
                  input frame_function, input frame_length, input last_of_run,
                  input comm_fault, output ready);
endinterface

// File: hw/rtl/gfsr_cfg_if.sv
// ----------------------------------------------------------------------------
// gfsr_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface gfsr_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [gfsr_pkg::CFG_IDX_W-1:0]    reg_index;
  logic [gfsr_pkg::CFG_DATA_W-1:0]   wdata;

  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

// File: hw/rtl/gap_framed_slave_frame_receiver_unit.sv
// ----------------------------------------------------------------------------
// gap_framed_slave_frame_receiver_unit
// Gap-framed bus slave receiver with CRC-16 check and silence watchdog.
// ----------------------------------------------------------------------------
// Usage:
//  - in_chan carries one request: a received byte (kind 0) or one framing
//    timer tick (kind 1). A run of gap_ticks ticks arms the receiver; the
//    next byte must equal own_address, then come function, length and body.
//  - out_chan returns every result of a request; last_of_run marks the last.
//    A request without a frame event gives one status-0 result that only
//    reports comm_fault. A good frame streams all its bytes (status 1).
//  - cfg_chan writes own_address (0), gap_ticks (1), fault_ticks (2); write
//    only while no request is in flight. Other indexes are ignored.
// Sequencing:
//  - A request is taken in the idle state; a single result is then loaded
//    into the output register once it is free. A good frame of N bytes
//    streams one byte per cycle while out_chan is ready (one frame buffer
//    read per cycle).
//  - The output register parts the channels: one new request is taken while
//    a finished result still waits. A stalled out_chan holds the stream.
// Reset: rst_n (synchronous) restores register defaults and the idle framing
// state; both ready signals are low during reset. The frame buffer is not
// cleared: every byte that is checked or streamed was written by its frame.
// ----------------------------------------------------------------------------
module gap_framed_slave_frame_receiver_unit #(
  parameter int unsigned BUFFER_DEPTH = gfsr_pkg::BUFFER_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  gfsr_in_if.sink     in_chan,
  gfsr_out_if.source  out_chan,
  gfsr_cfg_if.sink    cfg_chan
);

  gfsr_pkg::ctl_cmd_t     cmd;
  gfsr_pkg::dp_sts_t      sts;
  gfsr_pkg::out_payload_t payload;
  logic                   cfg_we;

  // configuration writes are always taken outside reset
  assign cfg_chan.ready = rst_n;
  assign cfg_we         = cfg_chan.valid && cfg_chan.ready;

  gfsr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  gfsr_datapath #(
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_kind     (in_chan.kind),
    .in_rx_byte  (in_chan.rx_byte),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_chan.reg_index),
    .cfg_wdata   (cfg_chan.wdata),
    .cmd         (cmd),
    .sts         (sts),
    .out_payload (payload)
  );

  // result payload fields
  assign out_chan.status         = payload.status;
  assign out_chan.frame_byte     = payload.frame_byte;
  assign out_chan.byte_index     = payload.byte_index;
  assign out_chan.frame_function = payload.frame_function;
  assign out_chan.frame_length   = payload.frame_length;
  assign out_chan.last_of_run    = payload.last_of_run;
  assign out_chan.comm_fault     = payload.comm_fault;

endmodule

// File: hw/rtl/gfsr_datapath.sv
// ----------------------------------------------------------------------------
// gfsr_datapath
// Framing state, running CRC, frame buffer memory, watchdog and the
// output payload register.
// ----------------------------------------------------------------------------
module gfsr_datapath #(
  parameter int unsigned BUFFER_DEPTH = gfsr_pkg::BUFFER_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_kind,
  input  logic [gfsr_pkg::BYTE_W-1:0]       in_rx_byte,
  input  logic                              cfg_we,
  input  logic [gfsr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [gfsr_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  gfsr_pkg::ctl_cmd_t                cmd,
  output gfsr_pkg::dp_sts_t                 sts,
  output gfsr_pkg::out_payload_t            out_payload
);

  localparam int unsigned MEM_DEPTH =
    (BUFFER_DEPTH < gfsr_pkg::FRAME_CAP) ? BUFFER_DEPTH : gfsr_pkg::FRAME_CAP;
  localparam int unsigned AW = $clog2(MEM_DEPTH);
  localparam logic [gfsr_pkg::BYTE_W-1:0] FRAME_LIMIT = 8'(MEM_DEPTH);
  localparam logic [gfsr_pkg::FAULT_W-1:0] SILENCE_MAX = '1;

  typedef enum logic [4:0] {
    PH_GAP  = 5'b00001,
    PH_ADDR = 5'b00010,
    PH_FUNC = 5'b00100,
    PH_LEN  = 5'b01000,
    PH_BODY = 5'b10000
  } rx_phase_t;

  // configuration
  logic [7:0]                     own_addr_r;
  logic [7:0]                     gap_ticks_r;
  logic [gfsr_pkg::FAULT_W-1:0]   fault_ticks_r;

  // framing state
  rx_phase_t                      phase_r, phase_nxt;
  logic [5:0]                     byte_count_r, byte_count_nxt;
  logic [7:0]                     expected_r, expected_nxt;
  logic [7:0]                     func_r, func_nxt;
  logic [7:0]                     gap_r, gap_nxt;
  logic [gfsr_pkg::FAULT_W-1:0]   silence_r, silence_nxt;
  logic                           fault_r, fault_nxt;
  logic [15:0]                    crc_r, crc_nxt;
  logic [7:0]                     prev_r, prev_nxt;
  gfsr_pkg::status_t              ev_status_r, ev_status_nxt;
  logic [5:0]                     emit_cnt_r;

  logic [7:0]                     mem [MEM_DEPTH];
  logic                           mem_we;
  logic [AW-1:0]                  mem_waddr;

  logic [15:0]                    crc_base, crc_upd;
  logic [5:0]                     bc_inc;
  logic [7:0]                     gap_inc;
  logic [gfsr_pkg::FAULT_W-1:0]   sil_inc;
  logic                           body_done;
  logic                           body_crc;
  logic                           crc_match;
  logic                           good_frame;

  assign crc_base  = (phase_r == PH_ADDR) ? gfsr_pkg::CRC_INIT : crc_r;
  assign crc_upd   = gfsr_pkg::crc16_byte(crc_base, in_rx_byte);
  assign bc_inc    = byte_count_r + 6'd1;
  assign gap_inc   = (gap_r == 8'hFF) ? gap_r : gap_r + 8'd1;
  assign sil_inc   = (silence_r == SILENCE_MAX) ? silence_r
                                                : silence_r + 26'd1;
  assign body_done = ({2'b00, bc_inc} >= expected_r);
  // a body byte enters the CRC unless it is one of the two trailing bytes
  assign body_crc  = (({2'b00, byte_count_r} + 8'd2) < expected_r);
  assign crc_match = (prev_r == crc_r[7:0]) && (in_rx_byte == crc_r[15:8]);
  assign good_frame = (in_kind != gfsr_pkg::KIND_TICK) && (phase_r == PH_BODY) &&
                      ({2'b00, byte_count_r} < expected_r) && body_done && crc_match;

  always_comb begin
    phase_nxt      = phase_r;
    byte_count_nxt = byte_count_r;
    expected_nxt   = expected_r;
    func_nxt       = func_r;
    gap_nxt        = gap_r;
    silence_nxt    = silence_r;
    fault_nxt      = fault_r;
    crc_nxt        = crc_r;
    prev_nxt       = prev_r;
    ev_status_nxt  = ev_status_r;
    mem_we         = 1'b0;
    mem_waddr      = byte_count_r[AW-1:0];
    if (cmd.accept) begin
      ev_status_nxt = gfsr_pkg::STS_NONE;
      if (in_kind != gfsr_pkg::KIND_TICK) begin
        gap_nxt = 8'd0;
        case (phase_r)
          PH_ADDR: begin
            if (in_rx_byte == own_addr_r) begin
              mem_we         = 1'b1;
              mem_waddr      = AW'(0);
              byte_count_nxt = 6'd1;
              crc_nxt        = crc_upd;
              prev_nxt       = in_rx_byte;
              phase_nxt      = PH_FUNC;
            end else begin
              phase_nxt = PH_GAP;
            end
          end
          PH_FUNC: begin
            mem_we         = 1'b1;
            mem_waddr      = AW'(1);
            func_nxt       = in_rx_byte;
            byte_count_nxt = 6'd2;
            crc_nxt        = crc_upd;
            prev_nxt       = in_rx_byte;
            phase_nxt      = PH_LEN;
          end
          PH_LEN: begin
            mem_we         = 1'b1;
            mem_waddr      = AW'(2);
            expected_nxt   = in_rx_byte;
            byte_count_nxt = 6'd3;
            prev_nxt       = in_rx_byte;
            if (in_rx_byte > gfsr_pkg::MIN_FRAME_LEN) begin
              crc_nxt = crc_upd;
            end
            if (in_rx_byte < gfsr_pkg::MIN_FRAME_LEN || in_rx_byte > FRAME_LIMIT) begin
              ev_status_nxt = gfsr_pkg::STS_LEN_ERR;
              phase_nxt     = PH_GAP;
            end else begin
              phase_nxt = PH_BODY;
            end
          end
          PH_BODY: begin
            if ({2'b00, byte_count_r} < expected_r) begin
              mem_we         = 1'b1;
              byte_count_nxt = bc_inc;
              prev_nxt       = in_rx_byte;
              if (body_crc) begin
                crc_nxt = crc_upd;
              end
              if (body_done) begin
                phase_nxt = PH_GAP;
                if (crc_match) begin
                  silence_nxt   = '0;
                  ev_status_nxt = gfsr_pkg::STS_GOOD;
                end else begin
                  ev_status_nxt = gfsr_pkg::STS_CRC_ERR;
                end
              end
            end
          end
          default: begin
          end
        endcase
      end else begin
        // framing gap timer
        if (phase_r != PH_ADDR) begin
          gap_nxt = gap_inc;
          if (gap_inc >= gap_ticks_r) begin
            byte_count_nxt = '0;
            expected_nxt   = '0;
            func_nxt       = '0;
            phase_nxt      = PH_ADDR;
          end
        end
        // silence watchdog
        if (!fault_r) begin
          silence_nxt = sil_inc;
          if (sil_inc >= fault_ticks_r) begin
            fault_nxt      = 1'b1;
            byte_count_nxt = '0;
            expected_nxt   = '0;
            func_nxt       = '0;
            gap_nxt        = '0;
            phase_nxt      = PH_GAP;
          end
        end else if (silence_r == '0) begin
          fault_nxt = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_addr_r    <= gfsr_pkg::OWN_ADDR_RST;
      gap_ticks_r   <= gfsr_pkg::GAP_TICKS_RST;
      fault_ticks_r <= gfsr_pkg::FAULT_TICKS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        gfsr_pkg::REG_OWN_ADDR:    own_addr_r    <= cfg_wdata[7:0];
        gfsr_pkg::REG_GAP_TICKS:   gap_ticks_r   <= cfg_wdata[7:0];
        gfsr_pkg::REG_FAULT_TICKS: fault_ticks_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_GAP;
      byte_count_r <= '0;
      expected_r   <= '0;
      func_r       <= '0;
      gap_r        <= '0;
      silence_r    <= '0;
      fault_r      <= 1'b0;
      ev_status_r  <= gfsr_pkg::STS_NONE;
      emit_cnt_r   <= '0;
    end else begin
      phase_r      <= phase_nxt;
      byte_count_r <= byte_count_nxt;
      expected_r   <= expected_nxt;
      func_r       <= func_nxt;
      gap_r        <= gap_nxt;
      silence_r    <= silence_nxt;
      fault_r      <= fault_nxt;
      ev_status_r  <= ev_status_nxt;
      if (cmd.accept) begin
        emit_cnt_r <= '0;
      end else if (cmd.load_emit) begin
        emit_cnt_r <= emit_cnt_r + 6'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    crc_r  <= crc_nxt;
    prev_r <= prev_nxt;
  end

  // frame buffer write port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= in_rx_byte;
    end
  end

  assign sts.good_frame = good_frame;
  assign sts.emit_last  = ((emit_cnt_r + 6'd1) == expected_r[5:0]);

  // output payload register; the frame buffer read lands here directly
  always_ff @(posedge clk) begin
    if (cmd.load_emit) begin
      out_payload.status         <= gfsr_pkg::STS_GOOD;
      out_payload.frame_byte     <= mem[emit_cnt_r[AW-1:0]];
      out_payload.byte_index     <= 5'(emit_cnt_r);
      out_payload.frame_function <= func_r;
      out_payload.frame_length   <= expected_r[5:0];
      out_payload.last_of_run    <= sts.emit_last;
      out_payload.comm_fault     <= fault_r;
    end else if (cmd.load_single) begin
      out_payload.status         <= ev_status_r;
      out_payload.frame_byte     <= '0;
      out_payload.byte_index     <= '0;
      out_payload.frame_function <= (ev_status_r != gfsr_pkg::STS_NONE) ? func_r : 8'd0;
      out_payload.frame_length   <= (ev_status_r == gfsr_pkg::STS_CRC_ERR) ?
                                    expected_r[5:0] : 6'd0;
      out_payload.last_of_run    <= 1'b1;
      out_payload.comm_fault     <= fault_r;
    end
  end

  // a watchdog fault always restarts framing
  a_fault_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(fault_r) |-> (phase_r == PH_GAP && gap_r == 8'd0))
    else $error("fault raised without receiver restart");

  // frame bytes are only streamed for a frame that passed CRC
  a_emit_good_only: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_emit |-> (ev_status_r == gfsr_pkg::STS_GOOD))
    else $error("frame byte streamed for a rejected frame");

endmodule

// File: hw/rtl/gfsr_ctrl.sv
// ----------------------------------------------------------------------------
// gfsr_ctrl
// Request sequencer: accepts one input request, then loads one result or
// streams a good frame into the output register.
// ----------------------------------------------------------------------------
module gfsr_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output gfsr_pkg::ctl_cmd_t  cmd,
  input  gfsr_pkg::dp_sts_t   sts
);

  typedef enum logic [2:0] {
    CS_IDLE   = 3'b001,
    CS_SINGLE = 3'b010,
    CS_EMIT   = 3'b100
  } ctl_state_t;

  ctl_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign in_ready  = rst_n && (state_r == CS_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || out_ready;

  always_comb begin
    state_nxt       = state_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    cmd             = '0;
    cmd.accept      = in_valid && in_ready;
    case (state_r)
      CS_IDLE: begin
        if (cmd.accept) begin
          state_nxt = sts.good_frame ? CS_EMIT : CS_SINGLE;
        end
      end
      CS_SINGLE: begin
        if (out_free) begin
          cmd.load_single = 1'b1;
          out_valid_nxt   = 1'b1;
          state_nxt       = CS_IDLE;
        end
      end
      CS_EMIT: begin
        if (out_free) begin
          cmd.load_emit = 1'b1;
          out_valid_nxt = 1'b1;
          if (sts.emit_last) begin
            state_nxt = CS_IDLE;
          end
        end
      end
      default: begin
        state_nxt = CS_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= CS_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept |=> (state_r == CS_SINGLE || state_r == CS_EMIT))
    else $error("request accepted but no result pending");

  a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load_single || cmd.load_emit) |=> out_valid_r)
    else $error("result loaded but not presented");

  a_emit_done: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load_emit && sts.emit_last) |=> (state_r == CS_IDLE))
    else $error("frame stream did not end on its last byte");

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the gap-framed slave frame receiver. A short table
// of directed requests is followed by random frame traffic under several
// register settings, with random stalls on the request and result channels.
// Each accepted request is run through a local model of the receiver; every
// result is compared field by field against the oldest expected result.
// ----------------------------------------------------------------------------
module tb_top;
  import gfsr_pkg::*;

  // Longest frame the receiver keeps
  localparam int unsigned FRAME_LIMIT =
    (BUFFER_DEPTH_DEF < FRAME_CAP) ? BUFFER_DEPTH_DEF : FRAME_CAP;

  // Index 3 is not decoded; a write there must change nothing
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam logic [FAULT_W-1:0] FAULT_TICKS_MAX = '1;
  localparam logic KIND_BYTE = 1'b0;

  // Cycles waited after the last expected result has arrived
  localparam int unsigned SETTLE_CYCLES = 40;

  // Framing phases of the receiver
  typedef enum logic [2:0] {
    RX_WAIT_GAP = 3'd0,
    RX_ADDR     = 3'd1,
    RX_FUNC     = 3'd2,
    RX_LEN      = 3'd3,
    RX_BODY     = 3'd4
  } rx_phase_t;

  // Directed table: a tick, a literal byte, or the CRC of the bytes so far
  typedef enum logic [1:0] {
    ROW_TICK   = 2'd0,
    ROW_BYTE   = 2'd1,
    ROW_CRC_LO = 2'd2,
    ROW_CRC_HI = 2'd3
  } row_op_t;

  typedef struct packed {
    row_op_t     op;
    logic [7:0]  value;
    logic        pinned;     // single result typed in below
    status_t     pin_status;
    logic [7:0]  pin_func;
  } stim_row_t;

  localparam int DIR_ROWS = 25;

  // Run with own_address A5, gap_ticks 1, fault_ticks at its maximum
  stim_row_t dir_table [DIR_ROWS] = '{
    '{ROW_TICK,   8'h00, 1'b1, STS_NONE,    8'h00},  // one tick arms
    '{ROW_BYTE,   8'h00, 1'b1, STS_NONE,    8'h00},  // foreign address, back to gap
    '{ROW_BYTE,   8'hA5, 1'b1, STS_NONE,    8'h00},  // byte while waiting: ignored
    '{ROW_TICK,   8'h00, 1'b1, STS_NONE,    8'h00},
    '{ROW_BYTE,   8'hA5, 1'b1, STS_NONE,    8'h00},
    '{ROW_BYTE,   8'h03, 1'b1, STS_NONE,    8'h00},
    '{ROW_BYTE,   8'h03, 1'b1, STS_LEN_ERR, 8'h03},  // length below minimum
    '{ROW_TICK,   8'h00, 1'b1, STS_NONE,    8'h00},
    '{ROW_BYTE,   8'hA5, 1'b1, STS_NONE,    8'h00},
    '{ROW_BYTE,   8'hFF, 1'b1, STS_NONE,    8'h00},
    '{ROW_BYTE,   8'h21, 1'b1, STS_LEN_ERR, 8'hFF},  // length over the buffer
    '{ROW_TICK,   8'h00, 1'b1, STS_NONE,    8'h00},
    '{ROW_TICK,   8'h00, 1'b1, STS_NONE,    8'h00},  // tick while armed
    '{ROW_BYTE,   8'hA5, 1'b1, STS_NONE,    8'h00},
    '{ROW_BYTE,   8'h10, 1'b1, STS_NONE,    8'h00},
    '{ROW_BYTE,   8'h05, 1'b1, STS_NONE,    8'h00},
    '{ROW_CRC_LO, 8'h00, 1'b0, STS_NONE,    8'h00},
    '{ROW_CRC_HI, 8'h00, 1'b0, STS_NONE,    8'h00},  // good 5-byte frame
    '{ROW_TICK,   8'h00, 1'b1, STS_NONE,    8'h00},
    '{ROW_BYTE,   8'hA5, 1'b1, STS_NONE,    8'h00},
    '{ROW_BYTE,   8'h00, 1'b1, STS_NONE,    8'h00},
    '{ROW_BYTE,   8'h06, 1'b1, STS_NONE,    8'h00},
    '{ROW_BYTE,   8'hFF, 1'b1, STS_NONE,    8'h00},
    '{ROW_BYTE,   8'h00, 1'b0, STS_NONE,    8'h00},
    '{ROW_BYTE,   8'h00, 1'b0, STS_NONE,    8'h00}   // CRC bytes wrong
  };

  logic clk;
  logic rst_n;

  gfsr_in_if  in_chan();
  gfsr_out_if out_chan();
  gfsr_cfg_if cfg_chan();

  gap_framed_slave_frame_receiver_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  // Typed expectation of the current request, driven alongside the payload
  // so that it is sampled at the same edge as the request itself
  logic       req_pinned;
  status_t    req_pin_status;
  logic [7:0] req_pin_func;

  // Settings known to the stimulus side
  logic [7:0] own_now;
  logic [7:0] gap_now;
  logic       calm = 1'b0;       // no stalls on either side
  int unsigned items_sent = 0;
  int unsigned mismatch_count = 0;

  // Receiver model state
  logic [7:0]         own_addr_q;
  logic [7:0]         gap_ticks_q;
  logic [FAULT_W-1:0] fault_ticks_q;
  rx_phase_t          rx_phase;
  logic [7:0]         frame_mem [FRAME_LIMIT];
  logic [5:0]         rx_count;
  logic [7:0]         len_field;
  logic [7:0]         func_field;
  logic [7:0]         gap_run;
  logic [FAULT_W-1:0] silence_run;
  logic               fault_on;

  out_payload_t frame_results_due [$];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop, well beyond the slowest legal run
  initial begin
    #20000000;
    $display("[gap_framed_slave_frame_receiver_unit] ERROR");
    $finish;
  end

  // One reflected CRC-16 byte update
  function automatic logic [15:0] crc16_step(input logic [15:0] acc, input logic [7:0] d);
    logic [15:0] a;
    a = acc ^ {8'h00, d};
    repeat (8) a = (a >> 1) ^ (a[0] ? CRC_POLY : 16'h0000);
    return a;
  endfunction

  // Advance the receiver model by one request; queue the results it yields
  task automatic predict_request(input logic kind, input logic [7:0] b, input logic pinned,
                                 input status_t pin_status, input logic [7:0] pin_func);
    out_payload_t run [$];
    out_payload_t r;
    logic [15:0]  crc;
    int unsigned  len;
    int unsigned  i;
    r = '0;
    if (kind == KIND_TICK) begin
      // gap timer runs in every phase but the armed one
      if (rx_phase != RX_ADDR) begin
        if (gap_run != 8'hFF) gap_run++;
        if (gap_run >= gap_ticks_q) begin
          rx_count   = '0;
          len_field  = '0;
          func_field = '0;
          rx_phase   = RX_ADDR;
        end
      end
      // silence watchdog; while faulted it only waits for a good frame
      if (!fault_on) begin
        if (silence_run != FAULT_TICKS_MAX) silence_run++;
        if (silence_run >= fault_ticks_q) begin
          fault_on   = 1'b1;
          rx_count   = '0;
          len_field  = '0;
          func_field = '0;
          gap_run    = '0;
          rx_phase   = RX_WAIT_GAP;
        end
      end else if (silence_run == '0) begin
        fault_on = 1'b0;
      end
    end else begin
      gap_run = '0;
      case (rx_phase)
        RX_ADDR: begin
          if (b == own_addr_q) begin
            frame_mem[0] = b;
            rx_count     = 6'd1;
            rx_phase     = RX_FUNC;
          end else begin
            rx_phase = RX_WAIT_GAP;
          end
        end
        RX_FUNC: begin
          func_field   = b;
          frame_mem[1] = b;
          rx_count     = 6'd2;
          rx_phase     = RX_LEN;
        end
        RX_LEN: begin
          len_field    = b;
          frame_mem[2] = b;
          rx_count     = 6'd3;
          if (b < MIN_FRAME_LEN || b > FRAME_LIMIT) begin
            r.status         = STS_LEN_ERR;
            r.frame_function = func_field;
            run.push_back(r);
            rx_phase = RX_WAIT_GAP;
          end else begin
            rx_phase = RX_BODY;
          end
        end
        RX_BODY: begin
          if (rx_count < len_field && rx_count < FRAME_LIMIT) begin
            frame_mem[rx_count] = b;
            rx_count++;
          end
          if (rx_count >= len_field) begin
            len = len_field;
            crc = CRC_INIT;
            for (i = 0; i < len - 2; i++) crc = crc16_step(crc, frame_mem[i]);
            // CRC travels low byte first
            if ({frame_mem[len-1], frame_mem[len-2]} == crc) begin
              silence_run = '0;
              for (i = 0; i < len; i++) begin
                r.status         = STS_GOOD;
                r.frame_byte     = frame_mem[i];
                r.byte_index     = IDX_W'(i);
                r.frame_function = func_field;
                r.frame_length   = LEN_W'(len);
                run.push_back(r);
              end
            end else begin
              r.status         = STS_CRC_ERR;
              r.frame_function = func_field;
              r.frame_length   = LEN_W'(len);
              run.push_back(r);
            end
            rx_phase = RX_WAIT_GAP;
          end
        end
        default: ;
      endcase
    end
    // typed-in rows replace the computed result; state still advances
    if (pinned) begin
      run.delete();
      r                = '0;
      r.status         = pin_status;
      r.frame_function = pin_func;
      run.push_back(r);
    end
    if (run.size() == 0) begin
      r = '0;
      run.push_back(r);
    end
    foreach (run[k]) begin
      run[k].comm_fault  = fault_on;
      run[k].last_of_run = (k == run.size() - 1);
      frame_results_due.push_back(run[k]);
    end
  endtask

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h got %0h", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  // Monitor: register writes, request prediction, result checking
  always @(posedge clk) begin
    out_payload_t want;
    if (!rst_n) begin
      own_addr_q    = OWN_ADDR_RST;
      gap_ticks_q   = GAP_TICKS_RST;
      fault_ticks_q = FAULT_TICKS_RST;
      rx_phase      = RX_WAIT_GAP;
      rx_count      = '0;
      len_field     = '0;
      func_field    = '0;
      gap_run       = '0;
      silence_run   = '0;
      fault_on      = 1'b0;
    end else begin
      if (cfg_chan.valid && cfg_chan.ready) begin
        case (cfg_chan.reg_index)
          REG_OWN_ADDR:    own_addr_q    = cfg_chan.wdata[7:0];
          REG_GAP_TICKS:   gap_ticks_q   = cfg_chan.wdata[7:0];
          REG_FAULT_TICKS: fault_ticks_q = cfg_chan.wdata[FAULT_W-1:0];
          default: ;
        endcase
      end
      if (in_chan.valid && in_chan.ready) begin
        predict_request(in_chan.kind, in_chan.rx_byte, req_pinned, req_pin_status,
                        req_pin_func);
      end
      if (out_chan.valid && out_chan.ready) begin
        if (frame_results_due.size() == 0) begin
          $display("%0t: result with nothing expected, status %0d byte %0h", $time,
                   out_chan.status, out_chan.frame_byte);
          mismatch_count++;
        end else begin
          want = frame_results_due.pop_front();
          check_field("status",         want.status,         out_chan.status);
          check_field("frame_byte",     want.frame_byte,     out_chan.frame_byte);
          check_field("byte_index",     want.byte_index,     out_chan.byte_index);
          check_field("frame_function", want.frame_function, out_chan.frame_function);
          check_field("frame_length",   want.frame_length,   out_chan.frame_length);
          check_field("last_of_run",    want.last_of_run,    out_chan.last_of_run);
          check_field("comm_fault",     want.comm_fault,     out_chan.comm_fault);
        end
      end
    end
  end

  // Result side back-pressure: random stall bursts, none once calm
  initial begin
    out_chan.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!calm && $urandom_range(0, 4) == 0) begin
        out_chan.ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end
      out_chan.ready <= 1'b1;
      repeat ($urandom_range(0, 20)) @(posedge clk);
    end
  end

  // Issue one request and hold it until taken. valid stays high into the
  // next request unless an idle burst comes first.
  task automatic send_req(input logic kind, input logic [7:0] val,
                          input logic pinned = 1'b0, input status_t pin_status = STS_NONE,
                          input logic [7:0] pin_func = 8'h00);
    int unsigned idle;
    if (!calm && $urandom_range(0, 3) == 0) begin
      idle = $urandom_range(1, 14);
      in_chan.valid <= 1'b0;
      repeat (idle) @(posedge clk);
    end
    in_chan.valid  <= 1'b1;
    in_chan.kind   <= kind;
    in_chan.rx_byte <= val;
    req_pinned     <= pinned;
    req_pin_status <= pin_status;
    req_pin_func   <= pin_func;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_chan.valid     <= 1'b1;
    cfg_chan.reg_index <= idx;
    cfg_chan.wdata     <= data;
    @(posedge clk);
    while (!cfg_chan.ready) @(posedge clk);
  endtask

  // Only called with nothing in flight. Junk above bit 7 must be dropped.
  task automatic program_regs(input logic [7:0] addr, input logic [7:0] gap,
                              input logic [FAULT_W-1:0] fault);
    cfg_write(REG_OWN_ADDR, {18'($urandom), addr});
    cfg_write(REG_GAP_TICKS, {18'($urandom), gap});
    cfg_write(REG_FAULT_TICKS, fault);
    cfg_write(REG_SPARE, 26'($urandom));
    cfg_chan.valid <= 1'b0;
    own_now = addr;
    gap_now = gap;
    repeat (2) @(posedge clk);
  endtask

  // Stop sending, let every expected result arrive, then let the block settle.
  // The monitor queues the last request's results at the edge it is taken,
  // so look at the queue only from the next edge on.
  task automatic wait_idle();
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (frame_results_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // A gap, then a frame: mostly well formed, sometimes foreign, bad length,
  // corrupted or cut short
  task automatic send_frame_sequence();
    logic [7:0]  fr [$];
    logic [15:0] crc;
    int unsigned len;
    int unsigned n_ticks;
    int unsigned pick;
    int unsigned i;
    n_ticks = (gap_now == 0) ? 1 : gap_now;
    n_ticks += $urandom_range(0, 1);
    repeat (n_ticks) send_req(KIND_TICK, 8'($urandom));

    pick = $urandom_range(0, 99);
    if (pick < 8)       len = FRAME_LIMIT;
    else if (pick < 14) len = MIN_FRAME_LEN;
    else if (pick < 22) len = $urandom_range(0, 1) ? $urandom_range(0, MIN_FRAME_LEN - 1)
                                                   : $urandom_range(FRAME_LIMIT + 1, 255);
    else if (pick < 30) len = $urandom_range(13, FRAME_LIMIT - 1);
    else                len = $urandom_range(5, 12);

    fr.push_back(($urandom_range(0, 9) == 0) ? own_now ^ 8'($urandom_range(1, 255)) : own_now);
    fr.push_back(8'($urandom));
    fr.push_back(8'(len));

    if (len >= MIN_FRAME_LEN && len <= FRAME_LIMIT) begin
      // shortest frame: the length byte is also the CRC low byte, so hunt for
      // a function code that makes the frame valid (may not exist)
      if (len == MIN_FRAME_LEN) begin
        for (i = 0; i < 256; i++) begin
          crc = crc16_step(crc16_step(CRC_INIT, fr[0]), 8'(i));
          if (crc[7:0] == MIN_FRAME_LEN) begin
            fr[1] = 8'(i);
            break;
          end
        end
      end
      while (fr.size() < len - 2) fr.push_back(8'($urandom));
      crc = CRC_INIT;
      for (i = 0; i < len - 2; i++) crc = crc16_step(crc, fr[i]);
      if (fr.size() == len - 2) fr.push_back(crc[7:0]);
      fr.push_back(crc[15:8]);
      if ($urandom_range(0, 6) == 0) begin
        i = $urandom_range(3, len - 1);
        fr[i] = fr[i] ^ 8'($urandom_range(1, 255));
      end
    end
    if ($urandom_range(0, 9) == 0) fr = fr[0:$urandom_range(0, fr.size() - 1)];

    foreach (fr[k]) begin
      // stray tick inside the frame; breaks it when the gap is short
      if ($urandom_range(0, 24) == 0) send_req(KIND_TICK, 8'($urandom));
      send_req(KIND_BYTE, fr[k]);
    end
  endtask

  task automatic run_phase(input int unsigned budget);
    int unsigned start;
    start = items_sent;
    while (items_sent - start < budget) begin
      if ($urandom_range(0, 9) < 7) begin
        send_frame_sequence();
      end else begin
        repeat ($urandom_range(1, 4)) send_req(1'($urandom_range(0, 1)), 8'($urandom));
      end
    end
  endtask

  initial begin
    stim_row_t   row;
    logic        kind;
    logic [7:0]  val;
    logic [15:0] crc_run;

    rst_n              <= 1'b0;
    in_chan.valid      <= 1'b0;
    in_chan.kind       <= KIND_BYTE;
    in_chan.rx_byte    <= 8'h00;
    cfg_chan.valid     <= 1'b0;
    cfg_chan.reg_index <= REG_OWN_ADDR;
    cfg_chan.wdata     <= '0;
    req_pinned         <= 1'b0;
    req_pin_status     <= STS_NONE;
    req_pin_func       <= 8'h00;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table; the running CRC restarts at every tick row
    program_regs(8'hA5, 8'd1, FAULT_TICKS_MAX);
    crc_run = CRC_INIT;
    foreach (dir_table[i]) begin
      row = dir_table[i];
      case (row.op)
        ROW_TICK: begin
          kind    = KIND_TICK;
          val     = 8'h00;
          crc_run = CRC_INIT;
        end
        ROW_BYTE: begin
          kind    = KIND_BYTE;
          val     = row.value;
          crc_run = crc16_step(crc_run, val);
        end
        ROW_CRC_LO: begin
          kind = KIND_BYTE;
          val  = crc_run[7:0];
        end
        default: begin
          kind = KIND_BYTE;
          val  = crc_run[15:8];
        end
      endcase
      send_req(kind, val, row.pinned, row.pin_status, row.pin_func);
    end
    wait_idle();

    // Zero gap: the first counted tick arms. Lowest address.
    program_regs(8'h00, 8'd0, FAULT_TICKS_MAX);
    run_phase(40);
    wait_idle();

    // Long gap, highest address
    program_regs(8'hFF, 8'd40, 26'd5000);
    run_phase(100);
    wait_idle();

    // Zero fault limit: the first counted tick raises the fault
    program_regs(8'h3C, 8'd3, '0);
    run_phase(40);
    wait_idle();

    // Short watchdog so faults come and go with the traffic
    program_regs(8'($urandom), 8'd2, 26'd12);
    run_phase(50);
    wait_idle();

    // Closing stretch without stalls
    calm = 1'b1;
    program_regs(8'($urandom), 8'($urandom_range(1, 6)), 26'($urandom_range(20, 60)));
    run_phase(50);
    wait_idle();

    if (mismatch_count == 0) begin
      $display("[gap_framed_slave_frame_receiver_unit] OK");
    end else begin
      $display("[gap_framed_slave_frame_receiver_unit] ERROR");
    end
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/gfsr_pkg.sv
hw/rtl/gfsr_in_if.sv
hw/rtl/gfsr_out_if.sv
hw/rtl/gfsr_cfg_if.sv
hw/rtl/gfsr_datapath.sv
hw/rtl/gfsr_ctrl.sv
hw/rtl/gap_framed_slave_frame_receiver_unit.sv
dv/tb_top.sv
